@@ hdl/pes_to_ts_packetizer_unit_macros.svh @@
// assertion macros shared by the packetizer rtl
// expects clk and rst_n in scope wherever a macro is used
`ifndef PES_TO_TS_PACKETIZER_UNIT_MACROS_SVH
`define PES_TO_TS_PACKETIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define P2TS_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("p2ts check failed");
// antecedent implies consequent in the same cycle
`define P2TS_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("p2ts check failed");
// antecedent implies consequent in the next cycle
`define P2TS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("p2ts check failed");
`else
`define P2TS_ASSERT_ALWAYS(name, expr)
`define P2TS_ASSERT_IMPLY(name, ante, cons)
`define P2TS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ hdl/p2ts_pkg.sv @@
// types, constants and descriptor layout for the transport packetizer
// no dependencies
`default_nettype none

package p2ts_pkg;

    // sizes
    localparam int NUM_STREAMS = 16;
    localparam int SLOT_W      = $clog2(NUM_STREAMS);
    localparam int LENGTH_BITS = 24;
    localparam int PID_W       = 13;
    localparam int DTS_W       = 42;
    localparam int PCR_W       = 33;
    localparam int CC_W        = 4;

    // operation codes of an input word
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // packet constants
    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] PAYLOAD_FULL = 8'd184;
    localparam logic [7:0] PAYLOAD_PCR  = 8'd176;
    localparam logic [7:0] AF_LEN_PCR   = 8'd7;
    localparam logic [7:0] AF_FLAG_PCR  = 8'h10;
    localparam logic [7:0] AF_FLAG_NONE = 8'h00;
    localparam logic [7:0] STUFF_BYTE   = 8'hff;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam logic [1:0] AFC_BOTH     = 2'b11;
    localparam logic [1:0] AFC_PAYLOAD  = 2'b01;

    // pcr: ((dts*9) >> 2) times ceil(2^49 / 25), quotient taken from bit 49 up,
    // one 32x32 partial product a cycle
    localparam int PCR_DIVISOR = 100;
    localparam int PCR_YW      = DTS_W + 2;
    localparam int PCR_MW      = 45;
    localparam int PCR_AW      = PCR_YW + PCR_MW;
    localparam int PCR_SHIFT   = 49;
    localparam logic [PCR_MW-1:0] PCR_RECIP = 45'd22517998136853;
    localparam int PCR_STEPS   = 4;
    localparam int PCR_CW      = $clog2(PCR_STEPS + 1);

    // descriptor queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [SLOT_W-1:0]      slot_t;
    typedef logic [PID_W-1:0]       pid_t;
    typedef logic [LENGTH_BITS-1:0] len_t;
    typedef logic [DTS_W-1:0]       dts_t;
    typedef logic [PCR_W-1:0]       pcr_t;
    typedef logic [CC_W-1:0]        cc_t;

    // one accepted payload byte, with the header of its packet if it opens one
    typedef struct packed {
        logic [7:0] data_byte;
        logic       pkt_end;
        logic       pkt_begin;
        logic       first;
        pid_t       pid;
        cc_t        cc;
        logic       adapt;
        logic       stamped;
        logic [7:0] stuffing;
        pcr_t       pcr;
    } desc_t;

    typedef struct packed {
        logic  push;
        desc_t desc;
    } fifo_wr_t;

    typedef struct packed {
        logic busy;
        pcr_t pcr;
    } pcr_stat_t;

endpackage

`default_nettype wire

@@ hdl/p2ts_ifs.sv @@
// valid/ready channel interfaces for pes input words and ts output words
// depends on p2ts_pkg
`default_nettype none

interface p2ts_in_if;
    logic                valid;
    logic                ready;
    logic                operation;
    p2ts_pkg::slot_t     stream_slot;
    p2ts_pkg::pid_t      pid;
    p2ts_pkg::len_t      pes_length;
    p2ts_pkg::dts_t      dts;
    logic                has_duration;
    logic [7:0]          data_byte;

    modport source (
        output valid, operation, stream_slot, pid, pes_length, dts, has_duration,
               data_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, stream_slot, pid, pes_length, dts, has_duration,
               data_byte,
        output ready
    );
endinterface

interface p2ts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [7:0] repeat_count;
    logic       packet_end;
    logic       last_of_run;

    modport source (
        output valid, out_byte, repeat_count, packet_end, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_byte, repeat_count, packet_end, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/p2ts_pcr_div.sv @@
// pcr unit: (dts * 9) / 100 mod 2^33 by reciprocal multiplication
// depends on p2ts_pkg and the assertion macro header
`default_nettype none
`include "pes_to_ts_packetizer_unit_macros.svh"

module p2ts_pcr_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  p2ts_pkg::dts_t       dts,
    output p2ts_pkg::pcr_stat_t  stat
);
    import p2ts_pkg::*;

    // step codes, counted down from the start
    localparam logic [PCR_CW-1:0] STEP_LL = PCR_CW'(4);
    localparam logic [PCR_CW-1:0] STEP_LH = PCR_CW'(3);
    localparam logic [PCR_CW-1:0] STEP_HL = PCR_CW'(2);
    localparam logic [PCR_CW-1:0] STEP_HH = PCR_CW'(1);

    logic [DTS_W+3:0]  x9;
    logic [PCR_YW-1:0] y_reg;
    logic [PCR_AW-1:0] acc_reg;
    logic [PCR_CW-1:0] cnt_reg;
    logic [31:0]       y_lo, y_hi, m_lo, m_hi;
    logic [31:0]       op_a, op_b;
    logic [63:0]       prod;
    logic [PCR_AW-1:0] addend;

    // dividend is dts times nine; dividing by four first leaves a division by 25
    assign x9 = {1'b0, dts, 3'b000} + {4'b0000, dts};

    // operand halves
    assign y_lo = y_reg[31:0];
    assign y_hi = 32'(y_reg[PCR_YW-1:32]);
    assign m_lo = PCR_RECIP[31:0];
    assign m_hi = 32'(PCR_RECIP[PCR_MW-1:32]);

    // operands of this step's partial product
    always_comb
    begin
        unique case (cnt_reg)
            STEP_LL:
            begin
                op_a = y_lo;
                op_b = m_lo;
            end
            STEP_LH:
            begin
                op_a = y_lo;
                op_b = m_hi;
            end
            STEP_HL:
            begin
                op_a = y_hi;
                op_b = m_lo;
            end
            STEP_HH:
            begin
                op_a = y_hi;
                op_b = m_hi;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // partial product aligned to its weight
    always_comb
    begin
        unique case (cnt_reg) inside
            STEP_LL:          addend = PCR_AW'(prod);
            STEP_LH, STEP_HL: addend = PCR_AW'({prod, 32'h0});
            STEP_HH:          addend = PCR_AW'({prod, 64'h0});
            default:          addend = '0;
        endcase
    end

    // step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= PCR_CW'(PCR_STEPS);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y_reg   <= x9[DTS_W+3:2];
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.pcr  = acc_reg[PCR_SHIFT +: PCR_W];

    `P2TS_ASSERT_NEXT(a_busy_after_start, start, cnt_reg == PCR_CW'(PCR_STEPS))
    `P2TS_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= PCR_CW'(PCR_STEPS))

endmodule

`default_nettype wire

@@ hdl/p2ts_front.sv @@
// input side: pes state, continuity counter memory and descriptor building
// depends on p2ts_pkg, p2ts_ifs, p2ts_pcr_div and the assertion macro header
`default_nettype none
`include "pes_to_ts_packetizer_unit_macros.svh"

module p2ts_front (
    input  logic               clk,
    input  logic               rst_n,
    p2ts_in_if.sink            pes_in,
    input  logic               fifo_full,
    output p2ts_pkg::fifo_wr_t wr
);
    import p2ts_pkg::*;

    // continuity counter memory, valid bit per entry stands for the reset zero
    cc_t                   cc_mem [NUM_STREAMS];
    logic [NUM_STREAMS-1:0] cc_vld_reg;
    cc_t                   cc_rdata_reg;
    logic                  cc_rvld_reg;

    // pes state
    slot_t      slot_reg;
    pid_t       pid_reg;
    len_t       br_reg, br_next;
    logic [7:0] plb_reg, plb_next;
    logic       dts_nz_reg;
    logic       first_reg, first_next;
    logic       open_reg, open_next;
    logic       cc_load_reg, cc_load_next;
    cc_t        cc_reg, cc_next;

    pcr_stat_t  pcr_stat;
    dts_t       eff_dts;

    logic       accept, start_go, data_go, pkt_begin, stamped, short_pkt, adapt;
    logic [7:0] payload, copy_len, stuffing, plb_after;
    len_t       br_after;
    cc_t        cc_cur, cc_inc;

    assign accept   = pes_in.valid && pes_in.ready;
    assign start_go = accept && (pes_in.operation == OP_START);
    assign data_go  = accept && (pes_in.operation == OP_DATA) && open_reg;

    // a zero stamp on a pes with duration counts as one
    assign eff_dts = (pes_in.dts == '0 && pes_in.has_duration) ? DTS_W'(1) : pes_in.dts;

    p2ts_pcr_div u_pcr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_go && (eff_dts != '0)),
        .dts   (eff_dts),
        .stat  (pcr_stat)
    );

    assign pes_in.ready = !fifo_full && !pcr_stat.busy;

    // counter of the open slot: straight from memory right after a start
    assign cc_cur = cc_load_reg ? (cc_rvld_reg ? cc_rdata_reg : '0) : cc_reg;
    assign cc_inc = cc_cur + 1'b1;

    // packet geometry
    assign pkt_begin = (plb_reg == '0);
    assign stamped   = first_reg && dts_nz_reg;
    assign payload   = stamped ? PAYLOAD_PCR : PAYLOAD_FULL;
    assign short_pkt = br_reg < {{(LENGTH_BITS-8){1'b0}}, payload};
    assign copy_len  = short_pkt ? br_reg[7:0] : payload;
    assign stuffing  = payload - copy_len;
    assign adapt     = stamped || short_pkt;
    assign plb_after = (pkt_begin ? copy_len : plb_reg) - 8'd1;
    assign br_after  = br_reg - 1'b1;

    // next state
    always_comb
    begin
        br_next      = br_reg;
        plb_next     = plb_reg;
        first_next   = first_reg;
        open_next    = open_reg;
        cc_load_next = cc_load_reg;
        cc_next      = cc_reg;
        if (start_go)
        begin
            br_next      = pes_in.pes_length;
            plb_next     = '0;
            first_next   = 1'b1;
            open_next    = (pes_in.pes_length != '0);
            cc_load_next = 1'b1;
        end
        else if (data_go)
        begin
            br_next  = br_after;
            plb_next = plb_after;
            if (pkt_begin)
            begin
                first_next   = 1'b0;
                cc_load_next = 1'b0;
                cc_next      = cc_inc;
            end
            if (br_after == '0)
            begin
                open_next = 1'b0;
                plb_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            br_reg      <= '0;
            plb_reg     <= '0;
            first_reg   <= 1'b0;
            open_reg    <= 1'b0;
            cc_load_reg <= 1'b0;
            cc_reg      <= '0;
            slot_reg    <= '0;
            pid_reg     <= '0;
            dts_nz_reg  <= 1'b0;
            cc_vld_reg  <= '0;
            cc_rvld_reg <= 1'b0;
        end
        else
        begin
            br_reg      <= br_next;
            plb_reg     <= plb_next;
            first_reg   <= first_next;
            open_reg    <= open_next;
            cc_load_reg <= cc_load_next;
            cc_reg      <= cc_next;
            if (start_go)
            begin
                slot_reg    <= pes_in.stream_slot;
                pid_reg     <= pes_in.pid;
                dts_nz_reg  <= (eff_dts != '0);
                cc_rvld_reg <= cc_vld_reg[pes_in.stream_slot];
            end
            if (data_go && pkt_begin)
                cc_vld_reg[slot_reg] <= 1'b1;
        end
    end

    // memory port: read on start, write back at each packet header
    always_ff @(posedge clk)
    begin
        if (data_go && pkt_begin)
            cc_mem[slot_reg] <= cc_inc;
        if (start_go)
            cc_rdata_reg <= cc_mem[pes_in.stream_slot];
    end

    // descriptor towards the queue
    always_comb
    begin
        wr.push           = data_go;
        wr.desc.data_byte = pes_in.data_byte;
        wr.desc.pkt_end   = (plb_after == '0);
        wr.desc.pkt_begin = pkt_begin;
        wr.desc.first     = first_reg;
        wr.desc.pid       = pid_reg;
        wr.desc.cc        = cc_cur;
        wr.desc.adapt     = adapt;
        wr.desc.stamped   = stamped;
        wr.desc.stuffing  = stuffing;
        wr.desc.pcr       = pcr_stat.pcr;
    end

    `P2TS_ASSERT_IMPLY(a_closed_idle, !open_reg, br_reg == '0 && plb_reg == '0)
    `P2TS_ASSERT_ALWAYS(a_plb_range, plb_reg <= PAYLOAD_FULL)

endmodule

`default_nettype wire

@@ hdl/p2ts_fifo.sv @@
// descriptor queue in a synchronous memory, head word prefetched into the read register
// depends on p2ts_pkg and the assertion macro header
`default_nettype none
`include "pes_to_ts_packetizer_unit_macros.svh"

module p2ts_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  p2ts_pkg::fifo_wr_t wr,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output p2ts_pkg::desc_t    head
);
    import p2ts_pkg::*;

    desc_t               mem [FIFO_DEPTH];
    desc_t               head_reg;
    logic                head_valid_reg;
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]    cnt_reg;
    logic                rd_en;

    // prefetch whenever a word is stored and the head register is free or being taken
    assign rd_en = (cnt_reg != '0) && (!head_valid_reg || pop);
    assign full  = (cnt_reg == (FIFO_AW + 1)'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (FIFO_AW + 1)'(wr.push) - (FIFO_AW + 1)'(rd_en);
            if (rd_en)
                head_valid_reg <= 1'b1;
            else if (pop)
                head_valid_reg <= 1'b0;
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (wr.push)
            mem[wr_ptr_reg] <= wr.desc;
        if (rd_en)
            head_reg <= mem[rd_ptr_reg];
    end

    assign head_valid = head_valid_reg;
    assign head       = head_reg;

    `P2TS_ASSERT_IMPLY(a_no_push_full, wr.push, !full)
    `P2TS_ASSERT_IMPLY(a_pop_head, pop, head_valid_reg)

endmodule

`default_nettype wire

@@ hdl/p2ts_expand.sv @@
// output sequencer: turns one descriptor into header, adaptation field and payload words
// depends on p2ts_pkg, p2ts_ifs and the assertion macro header
`default_nettype none
`include "pes_to_ts_packetizer_unit_macros.svh"

module p2ts_expand (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  p2ts_pkg::desc_t head,
    output logic            pop,
    p2ts_out_if.source      ts_out
);
    import p2ts_pkg::*;

    localparam logic [3:0] PH_START    = 4'd0;
    localparam logic [3:0] PH_SYNC     = 4'd1;
    localparam logic [3:0] PH_PID_HI   = 4'd2;
    localparam logic [3:0] PH_PID_LO   = 4'd3;
    localparam logic [3:0] PH_CC       = 4'd4;
    localparam logic [3:0] PH_AF_LEN   = 4'd5;
    localparam logic [3:0] PH_AF_FLAGS = 4'd6;
    localparam logic [3:0] PH_PCR0     = 4'd7;
    localparam logic [3:0] PH_PCR1     = 4'd8;
    localparam logic [3:0] PH_PCR2     = 4'd9;
    localparam logic [3:0] PH_PCR3     = 4'd10;
    localparam logic [3:0] PH_PCR4     = 4'd11;
    localparam logic [3:0] PH_PCR_EXT  = 4'd12;
    localparam logic [3:0] PH_STUFF    = 4'd13;
    localparam logic [3:0] PH_DATA     = 4'd14;

    logic [3:0] phase_reg, phase_next, cur_phase, after_phase;
    logic       out_valid_reg;
    logic [7:0] byte_reg, rep_reg;
    logic       end_reg, last_reg;
    logic [7:0] res_byte, res_rep;
    logic       load;

    assign load      = head_valid && (!out_valid_reg || ts_out.ready);
    assign cur_phase = (phase_reg == PH_START) ? (head.pkt_begin ? PH_SYNC : PH_DATA)
                                               : phase_reg;

    // word of the current phase and the phase after it
    always_comb
    begin
        res_byte    = ZERO_BYTE;
        res_rep     = 8'd1;
        after_phase = PH_DATA;
        unique case (cur_phase)
            PH_SYNC:
            begin
                res_byte    = SYNC_BYTE;
                after_phase = PH_PID_HI;
            end
            PH_PID_HI:
            begin
                res_byte    = {1'b0, head.first, 1'b0, head.pid[PID_W-1:8]};
                after_phase = PH_PID_LO;
            end
            PH_PID_LO:
            begin
                res_byte    = head.pid[7:0];
                after_phase = PH_CC;
            end
            PH_CC:
            begin
                res_byte    = {2'b00, head.adapt ? AFC_BOTH : AFC_PAYLOAD, head.cc};
                after_phase = head.adapt ? PH_AF_LEN : PH_DATA;
            end
            PH_AF_LEN:
            begin
                res_byte    = head.stamped ? (AF_LEN_PCR + head.stuffing)
                                           : (head.stuffing - 8'd1);
                after_phase = (head.stamped || head.stuffing > 8'd1) ? PH_AF_FLAGS : PH_DATA;
            end
            PH_AF_FLAGS:
            begin
                res_byte = head.stamped ? AF_FLAG_PCR : AF_FLAG_NONE;
                if (head.stamped)
                    after_phase = PH_PCR0;
                else
                    after_phase = (head.stuffing > 8'd2) ? PH_STUFF : PH_DATA;
            end
            PH_PCR0:
            begin
                res_byte    = head.pcr[32:25];
                after_phase = PH_PCR1;
            end
            PH_PCR1:
            begin
                res_byte    = head.pcr[24:17];
                after_phase = PH_PCR2;
            end
            PH_PCR2:
            begin
                res_byte    = head.pcr[16:9];
                after_phase = PH_PCR3;
            end
            PH_PCR3:
            begin
                res_byte    = head.pcr[8:1];
                after_phase = PH_PCR4;
            end
            PH_PCR4:
            begin
                res_byte    = {head.pcr[0], 7'b0000000};
                after_phase = PH_PCR_EXT;
            end
            PH_PCR_EXT:
            begin
                res_byte    = ZERO_BYTE;
                after_phase = (head.stuffing != '0) ? PH_STUFF : PH_DATA;
            end
            PH_STUFF:
            begin
                res_byte    = STUFF_BYTE;
                res_rep     = head.stamped ? head.stuffing : (head.stuffing - 8'd2);
                after_phase = PH_DATA;
            end
            PH_DATA:
            begin
                res_byte    = head.data_byte;
                after_phase = PH_START;
            end
            default:
            begin
                res_byte    = ZERO_BYTE;
                after_phase = PH_START;
            end
        endcase
    end

    assign pop        = load && (cur_phase == PH_DATA);
    assign phase_next = load ? after_phase : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (ts_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= res_byte;
            rep_reg  <= res_rep;
            end_reg  <= (cur_phase == PH_DATA) && head.pkt_end;
            last_reg <= (cur_phase == PH_DATA);
        end
    end

    assign ts_out.valid        = out_valid_reg;
    assign ts_out.out_byte     = byte_reg;
    assign ts_out.repeat_count = rep_reg;
    assign ts_out.packet_end   = end_reg;
    assign ts_out.last_of_run  = last_reg;

    `P2TS_ASSERT_IMPLY(a_phase_holds_head, phase_reg != PH_START, head_valid)

endmodule

`default_nettype wire

@@ hdl/pes_to_ts_packetizer_unit.sv @@
// pes to transport stream packetizer, top level
// input: one word a cycle while the 16-entry descriptor queue has room; a start word with a
//   timestamp holds ready low while the pcr unit runs (one partial product a cycle)
// output: one word a cycle while fed and ready; a packet's first byte yields 5 to 14 words,
//   so the output port sets the sustained rate; the first word passes the queue memory, its
//   head register and the output word register; reset: asynchronous, clears pes state, pcr
//   step count, queue, output sequencer and continuity valid bits at once, no sweep
`default_nettype none

module pes_to_ts_packetizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    p2ts_in_if.sink     pes_in,
    p2ts_out_if.source  ts_out
);
    import p2ts_pkg::*;

    fifo_wr_t wr;
    logic     fifo_full;
    logic     pop;
    logic     head_valid;
    desc_t    head;

    // pes state and header building
    p2ts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pes_in    (pes_in),
        .fifo_full (fifo_full),
        .wr        (wr)
    );

    // descriptor queue absorbing header bursts
    p2ts_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // word sequencer and output register
    p2ts_expand u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .ts_out     (ts_out)
    );

endmodule

`default_nettype wire
